// File: src/tapid_pkg.sv
// Shared widths, codes, state and command types for the two-axis PID regulator.
package tapid_pkg;

  // Field and datapath widths
  localparam int unsigned ANGLE_W    = 16;  // Q3.12 angle
  localparam int unsigned ERR_W      = 17;  // target minus measured
  localparam int unsigned DIFF_W     = 18;  // error minus last error
  localparam int unsigned STEP_W     = 16;  // Q0.16 step time
  localparam int unsigned GAIN_W     = 16;  // Q8.8 gain
  localparam int unsigned LIMIT_W    = 15;  // integral limit
  localparam int unsigned INTEG_W    = 16;  // integral accumulator
  localparam int unsigned IPROD_W    = 34;  // error times step
  localparam int unsigned IINC_W     = 18;  // rounded integral increment
  localparam int unsigned ISUM_W     = 19;  // integral before clamp
  localparam int unsigned DIV_NUM_W  = 33;  // |diff| << 16
  localparam int unsigned DERIV_W    = 34;  // signed derivative
  localparam int unsigned OPND_W     = 18;  // multiplier data operand
  localparam int unsigned MPROD_W    = 35;  // gain times operand
  localparam int unsigned ACC_W      = 52;  // Q.20 sum
  localparam int unsigned DHI_SHIFT  = 17;  // weight of derivative upper half
  localparam int unsigned FRAC_DROP  = 8;   // Q.20 to Q.12
  localparam int unsigned DRIVE_W    = 32;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 6;

  // Sequencing counts
  localparam int unsigned DIV_STEPS = DIV_NUM_W;
  localparam int unsigned NUM_TERMS = 4;

  // Register indexes; targets follow from CFG_TARGET_BASE, the limit after them
  localparam int unsigned CFG_GAIN_PROP   = 0;
  localparam int unsigned CFG_GAIN_INTEG  = 1;
  localparam int unsigned CFG_GAIN_DERIV  = 2;
  localparam int unsigned CFG_TARGET_BASE = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd410;  // 0.1 in Q3.12

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_INTEG,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

  // Products summed into the drive, one per multiply cycle
  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_DLO,
    TERM_DHI
  } term_e;

  typedef struct packed {
    logic  load;      // capture input item
    logic  prep;      // error product, divider start, clear sum
    logic  integ;     // integral update and clamp
    logic  div_step;  // one quotient bit
    logic  mul_en;    // multiply selected term
    term_e term;
    logic  d_load;    // register signed derivative
    logic  acc_add;   // add last product into sum
    logic  out_load;  // round, saturate, load result
  } cmd_t;

endpackage

// File: src/two_axis_pid_antiwindup.sv
// Top level of the two-axis PID regulator with integral clamp.
//
// Input stream (s_axis): one item per control step with the measured angle of
// each axis (signed Q3.12) and the step time (unsigned Q0.16 s). Output stream
// (m_axis): one item per input with the saturated 32-bit drive of each axis.
// Gains, targets and the integral limit are written through the cfg port; the
// user must write them only while the block is idle, which it does not enforce.
// Writes take effect at once. Each item passes in turn through capture, the
// error product, the integral update, the one-bit-per-cycle derivative divider
// and four multiplies through one multiplier per axis, then the final sum and
// the output load; the block accepts the next item only after that.
// The result sits in an output register: a new item is accepted while it
// waits; if the receiver still stalls when the next result is ready, the
// block holds in its final step until the register is free.
// Reset clears integrals and last errors, loads gains and targets with zero
// and the limit with 0.1; no clearing pass is needed.
module two_axis_pid_antiwindup #(
  parameter int unsigned AXES = 2,
  localparam int unsigned CFG_IDX_W = $clog2(AXES + 4),
  localparam int unsigned IN_W      = (AXES + 1) * tapid_pkg::ANGLE_W,
  localparam int unsigned OUT_W     = AXES * tapid_pkg::DRIVE_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // meas_roll, meas_pitch (one per axis), step_time
  input  logic [IN_W-1:0]                   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // drive_roll, drive_pitch (one per axis)
  output logic [OUT_W-1:0]                  m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [tapid_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import tapid_pkg::*;

  cmd_t cmd;

  tapid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  tapid_dp #(
    .AXES (AXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: src/tapid_div.sv
// Restoring divider, one quotient bit per cycle, for the derivative magnitude.
module tapid_div (
  input  logic                             clk_i,
  input  logic                             init_i,
  input  logic                             step_i,
  input  logic [tapid_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [tapid_pkg::STEP_W-1:0]     den_i,
  output logic [tapid_pkg::DIV_NUM_W-1:0]  quo_o
);
  import tapid_pkg::*;

  logic [STEP_W-1:0]    rem_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [STEP_W-1:0]    den_q;
  logic [STEP_W:0]      trial;
  logic [STEP_W:0]      trial_sub;
  logic                 fits;
  logic [STEP_W-1:0]    rem_nxt;

  // Shift in the next numerator bit and try the subtract
  assign trial     = {rem_q, quo_q[DIV_NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = (trial >= {1'b0, den_q});
  assign rem_nxt   = fits ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];

  // Numerator bits leave the top as quotient bits enter the bottom
  always_ff @(posedge clk_i) begin
    if (init_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (step_i) begin
      rem_q <= rem_nxt;
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign quo_o = quo_q;

endmodule

// File: src/tapid_dp.sv
// Datapath: configuration registers, per-axis error, integral, divider and MAC lanes.
module tapid_dp #(
  parameter int unsigned AXES = 2,
  localparam int unsigned CFG_IDX_W = $clog2(AXES + 4),
  localparam int unsigned IN_W      = (AXES + 1) * tapid_pkg::ANGLE_W,
  localparam int unsigned OUT_W     = AXES * tapid_pkg::DRIVE_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tapid_pkg::cmd_t                   cmd_i,
  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [tapid_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [IN_W-1:0]                   in_data_i,
  output logic [OUT_W-1:0]                  out_data_o
);
  import tapid_pkg::*;

  localparam int unsigned LIMIT_IDX = CFG_TARGET_BASE + AXES;

  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [ANGLE_W-1:0] target_q [AXES];
  logic [LIMIT_W-1:0] limit_q;
  logic [STEP_W-1:0]  step_q;
  logic               zstep_q;
  logic [GAIN_W-1:0]  gain_sel;
  logic               mshift_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      limit_q  <= LIMIT_RESET;
      for (int i = 0; i < AXES; i++) begin
        target_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_W'(CFG_GAIN_PROP)) begin
        gain_p_q <= cfg_wdata_i[GAIN_W-1:0];
      end
      if (cfg_idx_i == CFG_IDX_W'(CFG_GAIN_INTEG)) begin
        gain_i_q <= cfg_wdata_i[GAIN_W-1:0];
      end
      if (cfg_idx_i == CFG_IDX_W'(CFG_GAIN_DERIV)) begin
        gain_d_q <= cfg_wdata_i[GAIN_W-1:0];
      end
      for (int i = 0; i < AXES; i++) begin
        if (cfg_idx_i == CFG_IDX_W'(CFG_TARGET_BASE + i)) begin
          target_q[i] <= cfg_wdata_i[ANGLE_W-1:0];
        end
      end
      if (cfg_idx_i == CFG_IDX_W'(LIMIT_IDX)) begin
        limit_q <= cfg_wdata_i[LIMIT_W-1:0];
      end
    end
  end

  // Step time, shared by all axes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      step_q <= in_data_i[AXES*ANGLE_W +: STEP_W];
    end
    if (cmd_i.prep) begin
      zstep_q <= (step_q == '0);
    end
  end

  // Gain for the term being multiplied
  always_comb begin
    case (cmd_i.term)
      TERM_P:  gain_sel = gain_p_q;
      TERM_I:  gain_sel = gain_i_q;
      default: gain_sel = gain_d_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      mshift_q <= (cmd_i.term == TERM_DHI);
    end
  end

  // One lane per axis
  for (genvar a = 0; a < AXES; a++) begin : g_lane
    logic [ANGLE_W-1:0]        meas;
    logic [ERR_W-1:0]          e_d;
    logic signed [ERR_W-1:0]   e_q;
    logic signed [ERR_W-1:0]   prev_q;
    logic signed [INTEG_W-1:0] integ_q;
    logic signed [IPROD_W-1:0] iprod_q;
    logic signed [IPROD_W-1:0] iprod_rnd;
    logic signed [IINC_W-1:0]  iinc;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [ISUM_W-1:0]  lim_pos;
    logic signed [ISUM_W-1:0]  lim_neg;
    logic signed [ISUM_W-1:0]  iclamp;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_NUM_W-1:0]      quo;
    logic                      neg_q;
    logic signed [DERIV_W-1:0] d_mag;
    logic signed [DERIV_W-1:0] d_d;
    logic signed [DERIV_W-1:0] d_q;
    logic signed [OPND_W-1:0]  opnd;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [MPROD_W-1:0] mprod_d;
    logic signed [MPROD_W-1:0] mprod_q;
    logic signed [ACC_W-1:0]   addend;
    logic signed [ACC_W-1:0]   acc_q;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic [ACC_W-FRAC_DROP-1:0] acc_sh;
    logic                      ovf;
    logic [DRIVE_W-1:0]        drive_d;
    logic [DRIVE_W-1:0]        drive_q;

    // Error, exact in 17 bits
    assign meas = in_data_i[a*ANGLE_W +: ANGLE_W];
    assign e_d  = {target_q[a][ANGLE_W-1], target_q[a]} - {meas[ANGLE_W-1], meas};

    // Derivative numerator as sign and magnitude
    assign diff     = {e_q[ERR_W-1], e_q} - {prev_q[ERR_W-1], prev_q};
    assign diff_mag = diff[DIFF_W-1] ? -diff : diff;
    assign div_num  = {diff_mag[ERR_W-1:0], {STEP_W{1'b0}}};

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        e_q <= $signed(e_d);
      end
      if (cmd_i.prep) begin
        iprod_q <= IPROD_W'(e_q) * $signed(IPROD_W'(step_q));
        neg_q   <= diff[DIFF_W-1];
      end
    end

    // Persistent per-axis state
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prev_q  <= '0;
        integ_q <= '0;
      end else begin
        if (cmd_i.prep) begin
          prev_q <= e_q;
        end
        if (cmd_i.integ) begin
          integ_q <= iclamp[INTEG_W-1:0];
        end
      end
    end

    // Integral: round error*step to Q3.12, add, clamp to +/- limit
    assign iprod_rnd = iprod_q + IPROD_W'(32768);
    assign iinc      = iprod_rnd[IPROD_W-1:STEP_W];
    assign isum      = {{(ISUM_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q}
                     + {{(ISUM_W-IINC_W){iinc[IINC_W-1]}}, iinc};
    assign lim_pos   = $signed({{(ISUM_W-LIMIT_W){1'b0}}, limit_q});
    assign lim_neg   = -lim_pos;

    always_comb begin
      if (isum > lim_pos) begin
        iclamp = lim_pos;
      end else if (isum < lim_neg) begin
        iclamp = lim_neg;
      end else begin
        iclamp = isum;
      end
    end

    tapid_div u_div (
      .clk_i  (clk_i),
      .init_i (cmd_i.prep),
      .step_i (cmd_i.div_step),
      .num_i  (div_num),
      .den_i  (step_q),
      .quo_o  (quo)
    );

    // Signed derivative, zero for a zero step
    assign d_mag = $signed({1'b0, quo});
    always_comb begin
      if (zstep_q) begin
        d_d = '0;
      end else if (neg_q) begin
        d_d = -d_mag;
      end else begin
        d_d = d_mag;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.d_load) begin
        d_q <= d_d;
      end
    end

    // Operand for the term; the derivative goes in two halves
    always_comb begin
      case (cmd_i.term)
        TERM_P:   opnd = {e_q[ERR_W-1], e_q};
        TERM_I:   opnd = {{(OPND_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
        TERM_DLO: opnd = $signed({1'b0, d_q[DHI_SHIFT-1:0]});
        TERM_DHI: opnd = {d_q[DERIV_W-1], d_q[DERIV_W-1:DHI_SHIFT]};
        default:  opnd = '0;
      endcase
    end

    assign gain_s  = $signed({1'b0, gain_sel});
    assign mprod_d = MPROD_W'(opnd) * MPROD_W'(gain_s);

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul_en) begin
        mprod_q <= mprod_d;
      end
    end

    // Accumulate the Q.20 sum
    assign addend = mshift_q ? {mprod_q, {DHI_SHIFT{1'b0}}}
                             : {{(ACC_W-MPROD_W){mprod_q[MPROD_W-1]}}, mprod_q};

    always_ff @(posedge clk_i) begin
      if (cmd_i.prep) begin
        acc_q <= '0;
      end else if (cmd_i.acc_add) begin
        acc_q <= acc_q + addend;
      end
    end

    // Round to Q.12 and saturate to 32 bits
    assign acc_rnd = acc_q + ACC_W'(128);
    assign acc_sh  = acc_rnd[ACC_W-1:FRAC_DROP];
    assign ovf     = (acc_sh[ACC_W-FRAC_DROP-1:DRIVE_W-1] != '0)
                  && (acc_sh[ACC_W-FRAC_DROP-1:DRIVE_W-1] != '1);

    always_comb begin
      if (!ovf) begin
        drive_d = acc_sh[DRIVE_W-1:0];
      end else if (acc_sh[ACC_W-FRAC_DROP-1]) begin
        drive_d = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
        drive_d = {1'b0, {(DRIVE_W-1){1'b1}}};
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.out_load) begin
        drive_q <= drive_d;
      end
    end

    assign out_data_o[a*DRIVE_W +: DRIVE_W] = drive_q;
  end

endmodule

// File: src/tapid_ctrl.sv
// Controller: sequences capture, integral, divide, multiply-accumulate and output.
module tapid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tapid_pkg::cmd_t cmd_o
);
  import tapid_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ov_q, ov_d;
  logic             slot_free;

  assign slot_free = !ov_q || out_ready_i;

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(NUM_TERMS - 1)) begin
          state_d = ST_SUM;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SUM: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath commands and input handshake
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:  cmd_o.prep     = 1'b1;
      ST_INTEG: cmd_o.integ    = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.term    = term_e'(cnt_q[1:0]);
        cmd_o.d_load  = (cnt_q == '0);
        cmd_o.acc_add = (cnt_q != '0);
      end
      ST_SUM:  cmd_o.acc_add  = 1'b1;
      ST_DONE: cmd_o.out_load = slot_free;
      default: cmd_o = '0;
    endcase
  end

  // Result register occupancy
  always_comb begin
    if (cmd_o.out_load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

`ifndef SYNTH
  // Accepted item starts the sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_PREP))
    else $error("accepted item did not start processing");

  // Divider runs its full bit count before the multiplies
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> (state_q == ST_MUL))
    else $error("divide sequence length wrong");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!ov_q || out_ready_i))
    else $error("result overwritten while stalled");

  // A new result appears only out of the done state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == ST_DONE))
    else $error("result valid without finished item");
`endif

endmodule
